@@ hdl/bta_pkg.sv @@
`default_nettype none
package bta_pkg;

	localparam int CLIENTS     = 16;
	localparam int TICKET_BITS = 16;
	localparam int IDX_W       = $clog2(CLIENTS);
	localparam int CNT_W       = $clog2(CLIENTS + 1);
	localparam int CLIENT_W    = 4;
	localparam int ACTIVE_W    = 5;
	localparam int GIVEN_W     = 16;
	localparam int STATUS_W    = 2;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);
	localparam logic [TICKET_BITS-1:0] TICKET_CEIL = '1;

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd2;

	typedef struct packed {
		logic                action;
		logic [CLIENT_W-1:0] client;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GIVEN_W-1:0]  ticket_given;
		logic                grant_valid;
		logic [CLIENT_W-1:0] grant_client;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_zero;
		logic last_rd;
	} sts_t;

endpackage
`default_nettype wire

@@ hdl/bakery_ticket_arbiter.sv @@
// Channel   Signals                     Moves on
// -------   -------------------------   ---------------------------------------
// item      start, busy, req            rising edge with start high, busy low
// result    done, rsp                   rising edge ending the one-cycle done
// config    cfg_we, cfg_wdata           rising edge with cfg_we high
//
// The done beat follows the ticket scan, and the next item can be taken once
// the controller is back in idle after done. The scan reads one ticket per
// live client (the configured count, capped at sixteen) through a single read
// port; then come a drain, decide, result and idle state. With a count of zero
// no ticket is read and the drain is skipped.
// busy stays high from accept through the done beat.
// Reset clears the ticket valid bits, the controller and active_clients (16);
// no clearing pass is needed. The receiver cannot stall: a result beat is valid
// on rsp while done is high, and rsp holds it until the next item's decide.
`default_nettype none
module bakery_ticket_arbiter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire bta_pkg::item_t                req,
	output logic                               done,
	output bta_pkg::result_t                   rsp,
	input  wire logic                          cfg_we,
	input  wire logic [bta_pkg::ACTIVE_W-1:0]  cfg_wdata
);
	import bta_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the scan, update and result beat
	bta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold the ticket memory, scan for max and min, apply the request or release
	bta_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ hdl/bta_ctrl.sv @@
`default_nettype none
module bta_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire bta_pkg::sts_t sts,
	output bta_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import bta_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.n_zero) state_nxt = ST_DECIDE;
				else if (sts.last_rd) state_nxt = ST_DRAIN;
			end
			ST_DRAIN:  state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = ST_EMIT;
			ST_EMIT:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCAN:   cmd.rd = !sts.n_zero;
			ST_DRAIN:  cmd = '0;
			ST_DECIDE: cmd.finish = 1'b1;
			ST_EMIT:   done = 1'b1;
			default:   cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/bta_dpath.sv @@
`default_nettype none
module bta_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bta_pkg::item_t                req,
	input  wire logic                          cfg_we,
	input  wire logic [bta_pkg::ACTIVE_W-1:0]  cfg_wdata,
	input  wire bta_pkg::cmd_t                 cmd,
	output bta_pkg::sts_t                      sts,
	output bta_pkg::result_t                   rsp
);
	import bta_pkg::*;

	logic [ACTIVE_W-1:0]    active_q;
	item_t                  item_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       n_live;

	logic [TICKET_BITS-1:0] mem [CLIENTS];
	logic [CLIENTS-1:0]     valid_q;
	logic [TICKET_BITS-1:0] rd_data_s1;
	logic                   rd_ok_s1;
	logic                   rd_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TICKET_BITS-1:0] rd_eff;

	logic [TICKET_BITS-1:0] max_q;
	logic [TICKET_BITS-1:0] own_q;
	logic                   min_found_q;
	logic [TICKET_BITS-1:0] min_t_q;
	logic [IDX_W-1:0]       min_idx_q;

	logic                   in_range;
	logic                   wr_en;
	logic [TICKET_BITS-1:0] wr_val;
	logic [TICKET_BITS-1:0] own_new;
	logic [IDX_W-1:0]       cl_idx;
	result_t                res_nxt;
	result_t                rsp_q;

	assign n_live = (32'(active_q) > CLIENTS) ? CNT_W'(CLIENTS) : CNT_W'(active_q);
	assign sts = '{n_zero: (n_q == '0), last_rd: (CNT_W'(idx_q + 1'b1) == n_q)};
	assign cl_idx = IDX_W'(item_q.client);
	assign rd_eff = rd_ok_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// ticket memory: one read port for the scan, one write port for the update
	always_ff @(posedge clk) begin
		if (cmd.finish && wr_en) mem[cl_idx] <= wr_val;
		rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_s1    <= 1'b0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (cmd.finish && wr_en) valid_q[cl_idx] <= (wr_val != '0);
			rd_s1    <= cmd.rd;
			rd_ok_s1 <= valid_q[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		if (cmd.load) begin
			item_q      <= req;
			n_q         <= n_live;
			idx_q       <= '0;
			max_q       <= '0;
			own_q       <= '0;
			min_found_q <= 1'b0;
			min_t_q     <= '0;
			min_idx_q   <= '0;
		end else begin
			if (cmd.rd) idx_q <= CNT_W'(idx_q + 1'b1);
			if (rd_s1) begin
				if (rd_eff > max_q) max_q <= rd_eff;
				// own slot is merged after the update; the rest ascend so ties keep the lower number
				if (32'(idx_s1) == 32'(item_q.client)) begin
					own_q <= rd_eff;
				end else if (rd_eff != '0 && (!min_found_q || rd_eff < min_t_q)) begin
					min_found_q <= 1'b1;
					min_t_q     <= rd_eff;
					min_idx_q   <= idx_s1;
				end
			end
		end
	end

	always_comb begin
		in_range = 32'(item_q.client) < 32'(n_q);
		wr_en    = 1'b0;
		wr_val   = '0;
		own_new  = own_q;
		res_nxt  = '0;
		res_nxt.status = STATUS_IGNORED;
		if (in_range) begin
			if (item_q.action == ACT_REQUEST) begin
				if (own_q == '0) begin
					if (max_q == TICKET_CEIL) begin
						res_nxt.status = STATUS_OVERFLOW;
					end else begin
						wr_en   = 1'b1;
						wr_val  = TICKET_BITS'(max_q + 1'b1);
						own_new = wr_val;
						res_nxt.status       = STATUS_DONE;
						res_nxt.ticket_given = GIVEN_W'(wr_val);
					end
				end
			end else if (own_q != '0) begin
				wr_en   = 1'b1;
				own_new = '0;
				res_nxt.status = STATUS_DONE;
			end
		end
		if (in_range && own_new != '0 && (!min_found_q || own_new < min_t_q ||
				(own_new == min_t_q && 32'(item_q.client) < 32'(min_idx_q)))) begin
			res_nxt.grant_valid  = 1'b1;
			res_nxt.grant_client = item_q.client;
		end else if (min_found_q) begin
			res_nxt.grant_valid  = 1'b1;
			res_nxt.grant_client = CLIENT_W'(min_idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) rsp_q <= res_nxt;
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

@@ hdl/bta_checker.sv @@
`default_nettype none
module bta_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire bta_pkg::result_t              rsp
);
	import bta_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat outside an item");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.grant_valid) |-> (rsp.grant_client == '0))
		else $error("grant client set without a grant");

	a_ticket_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != STATUS_DONE) |-> (rsp.ticket_given == '0))
		else $error("ticket given on a refused or ignored item");

endmodule

bind bakery_ticket_arbiter bta_checker u_bta_checker (.*);
`default_nettype wire
